>>> rtl/core/positional_list_engine_defines.svh
// Assertion macros used by the positional list engine sequencer RTL.
`ifndef POSITIONAL_LIST_ENGINE_DEFINES_SVH
`define POSITIONAL_LIST_ENGINE_DEFINES_SVH

// Same-cycle implication, sampled on clk_i, off while rst_ni is low.
`define PLE_ASSERT_IMPL(label, cond, conseq, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond) |-> (conseq)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i, off while rst_ni is low.
`define PLE_ASSERT_NEXT(label, cond, conseq, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond) |=> (conseq)) \
    else $error(msg);

`endif

>>> rtl/core/ple_pkg.sv
// Types and constants of the positional list engine.
`timescale 1ns / 1ps
package ple_pkg;

  localparam int unsigned DATA_W = 32;
  localparam int unsigned MODE_W = 3;
  localparam int unsigned PIN_W  = 6;
  localparam int unsigned POS_W  = 7;
  localparam int unsigned STAT_W = 3;
  localparam int unsigned CMP_W  = 8;

  typedef enum logic [MODE_W-1:0] {
    MODE_DUMP    = 3'd0,
    MODE_INSERT  = 3'd1,
    MODE_DELETE  = 3'd2,
    MODE_SWAP    = 3'd3,
    MODE_REVERSE = 3'd4,
    MODE_FIND    = 3'd5
  } ple_mode_e;

  typedef enum logic [STAT_W-1:0] {
    STAT_OK       = 3'd0,
    STAT_BADPOS   = 3'd1,
    STAT_FULL     = 3'd2,
    STAT_NOTFOUND = 3'd3,
    STAT_EMPTY    = 3'd4
  } ple_status_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CHECK,
    ST_DUMP_RD,
    ST_DUMP_EMIT,
    ST_INS_RD,
    ST_INS_WR,
    ST_INS_PUT,
    ST_DEL_RD,
    ST_DEL_WR,
    ST_SW_RDA,
    ST_SW_RDB,
    ST_SW_WRA,
    ST_SW_WRB,
    ST_FIND_RD,
    ST_FIND_CMP,
    ST_REPLY
  } ple_state_e;

  typedef struct packed {
    ple_status_e               status;
    logic [POS_W-1:0]          position;
    logic signed [DATA_W-1:0]  element_value;
    logic [POS_W-1:0]          element_count;
    logic                      last;
  } ple_result_t;

endpackage

>>> rtl/core/positional_list_engine.sv
// Top level of the positional list engine: store, sequencer and result register.
//
//  channel   dir  handshake                   tdata / tuser
//  s_axis    in   s_axis_tvalid/tready        tdata: pos_first, pos_second, value; tuser: mode
//  m_axis    out  m_axis_tvalid/tready        tdata: position, element_value, element_count;
//                                             tuser: status; tlast: last
//
// Each item walks the element store (one write, one read port): a dump reads and emits
// each element, an insert shifts elements up from the end to its position and puts the
// value, a delete shifts later elements down, a swap reads both then writes both, a
// reverse swaps pairs from the ends inward, and a find reads until a match or the list's end.
// Reset empties the list at once; the store itself needs no clearing pass.
// The input is not ready while an item is in work; a result waits in the output register,
// and a dump stalls between elements until its last result is taken.
`timescale 1ns / 1ps
module positional_list_engine #(
  parameter int unsigned CAPACITY = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [5:0] pos_first, [11:6] pos_second, [43:12] value, [47:44] zero
  input  logic [47:0] s_axis_tdata,
  // [2:0] mode
  input  logic [2:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [6:0] position, [38:7] element_value, [45:39] element_count, [47:46] zero
  output logic [47:0] m_axis_tdata,
  // [2:0] status
  output logic [2:0]  m_axis_tuser,
  output logic        m_axis_tlast
);

  localparam int unsigned AW = $clog2(CAPACITY);
  localparam int unsigned CW = $clog2(CAPACITY + 1);

  logic                              res_valid, out_free, out_valid_q;
  ple_pkg::ple_result_t              res, out_q;
  logic                              mem_we, mem_re;
  logic [AW-1:0]                     mem_waddr, mem_raddr;
  logic signed [ple_pkg::DATA_W-1:0] mem_wdata, mem_rdata;

  assign out_free = !out_valid_q || m_axis_tready;

  ple_ctrl #(
    .CAPACITY (CAPACITY),
    .AW       (AW),
    .CW       (CW)
  ) u_ctrl (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .req_valid_i      (s_axis_tvalid),
    .req_ready_o      (s_axis_tready),
    .req_mode_i       (s_axis_tuser),
    .req_pos_first_i  (s_axis_tdata[5:0]),
    .req_pos_second_i (s_axis_tdata[11:6]),
    .req_value_i      (s_axis_tdata[43:12]),
    .res_valid_o      (res_valid),
    .res_ready_i      (out_free),
    .res_o            (res),
    .mem_we_o         (mem_we),
    .mem_waddr_o      (mem_waddr),
    .mem_wdata_o      (mem_wdata),
    .mem_re_o         (mem_re),
    .mem_raddr_o      (mem_raddr),
    .mem_rdata_i      (mem_rdata)
  );

  ple_ram #(
    .DEPTH (CAPACITY),
    .AW    (AW)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  // Output register: load a new result when the slot is empty or being drained.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free && res_valid) begin
      out_q <= res;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {2'b00, out_q.element_count, out_q.element_value, out_q.position};
  assign m_axis_tuser  = out_q.status;
  assign m_axis_tlast  = out_q.last;

endmodule

>>> rtl/core/ple_ram.sv
// Element store: one write port, one registered read port.
`timescale 1ns / 1ps
module ple_ram #(
  parameter int unsigned DEPTH = 32,
  parameter int unsigned AW    = 5
) (
  input  logic                              clk_i,
  input  logic                              we_i,
  input  logic [AW-1:0]                     waddr_i,
  input  logic signed [ple_pkg::DATA_W-1:0] wdata_i,
  input  logic                              re_i,
  input  logic [AW-1:0]                     raddr_i,
  output logic signed [ple_pkg::DATA_W-1:0] rdata_o
);

  logic signed [ple_pkg::DATA_W-1:0] mem_q [DEPTH];
  logic signed [ple_pkg::DATA_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Hold read data until the next read is issued.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> rtl/core/ple_ctrl.sv
// Sequencer: walks the element store one access at a time for each request; a new request is taken only in idle.
`timescale 1ns / 1ps
`include "positional_list_engine_defines.svh"
module ple_ctrl #(
  parameter int unsigned CAPACITY = 32,
  parameter int unsigned AW       = 5,
  parameter int unsigned CW       = 6
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              req_valid_i,
  output logic                              req_ready_o,
  input  logic [ple_pkg::MODE_W-1:0]        req_mode_i,
  input  logic [ple_pkg::PIN_W-1:0]         req_pos_first_i,
  input  logic [ple_pkg::PIN_W-1:0]         req_pos_second_i,
  input  logic signed [ple_pkg::DATA_W-1:0] req_value_i,
  output logic                              res_valid_o,
  input  logic                              res_ready_i,
  output ple_pkg::ple_result_t              res_o,
  output logic                              mem_we_o,
  output logic [AW-1:0]                     mem_waddr_o,
  output logic signed [ple_pkg::DATA_W-1:0] mem_wdata_o,
  output logic                              mem_re_o,
  output logic [AW-1:0]                     mem_raddr_o,
  input  logic signed [ple_pkg::DATA_W-1:0] mem_rdata_i
);

  ple_pkg::ple_state_e  state_q, state_d;
  ple_pkg::ple_mode_e   mode_q, mode_d;
  ple_pkg::ple_status_e status_q, status_d;
  logic [ple_pkg::PIN_W-1:0]         p1_q, p1_d, p2_q, p2_d;
  logic signed [ple_pkg::DATA_W-1:0] val_q, val_d, tmp_q, tmp_d;
  logic [ple_pkg::POS_W-1:0]         pos_q, pos_d;
  logic [CW-1:0]                     count_q, count_d;
  logic [CW-1:0]                     a_q, a_d, b_q, b_d;
  logic [CW-1:0]                     a_inc, a_dec, p1_idx, p2_idx;
  logic [ple_pkg::CMP_W-1:0]         p1_w, p2_w, cnt_w;
  logic                              accept, p1_in_list, p2_in_list, p1_ins_ok;
  logic                              rev_more, a_match;

  assign req_ready_o = (state_q == ple_pkg::ST_IDLE);
  assign accept      = req_valid_i && req_ready_o;

  assign a_inc  = a_q + CW'(1);
  assign a_dec  = a_q - CW'(1);
  assign p1_idx = CW'(p1_q) - CW'(1);
  assign p2_idx = CW'(p2_q) - CW'(1);
  assign p1_w   = ple_pkg::CMP_W'(p1_q);
  assign p2_w   = ple_pkg::CMP_W'(p2_q);
  assign cnt_w  = ple_pkg::CMP_W'(count_q);

  assign p1_in_list = (p1_w != '0) && (p1_w <= cnt_w);
  assign p2_in_list = (p2_w != '0) && (p2_w <= cnt_w);
  assign p1_ins_ok  = (p1_w != '0) && (p1_w <= cnt_w + ple_pkg::CMP_W'(1));
  // Another pair remains when the next low index stays below the next high one.
  assign rev_more   = ({1'b0, a_q} + (CW+1)'(2)) < {1'b0, b_q};
  assign a_match    = (mem_rdata_i == val_q);

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ple_pkg::ST_IDLE: begin
        if (accept) state_d = ple_pkg::ST_CHECK;
      end
      ple_pkg::ST_CHECK: begin
        case (mode_q)
          ple_pkg::MODE_DUMP: begin
            state_d = (count_q == '0) ? ple_pkg::ST_REPLY : ple_pkg::ST_DUMP_RD;
          end
          ple_pkg::MODE_INSERT: begin
            if (!p1_ins_ok || count_q == CW'(CAPACITY)) state_d = ple_pkg::ST_REPLY;
            else state_d = ple_pkg::ST_INS_RD;
          end
          ple_pkg::MODE_DELETE: begin
            state_d = p1_in_list ? ple_pkg::ST_DEL_RD : ple_pkg::ST_REPLY;
          end
          ple_pkg::MODE_SWAP: begin
            state_d = (p1_in_list && p2_in_list) ? ple_pkg::ST_SW_RDA : ple_pkg::ST_REPLY;
          end
          ple_pkg::MODE_REVERSE: begin
            state_d = (count_q < CW'(2)) ? ple_pkg::ST_REPLY : ple_pkg::ST_SW_RDA;
          end
          ple_pkg::MODE_FIND: begin
            state_d = (count_q == '0) ? ple_pkg::ST_REPLY : ple_pkg::ST_FIND_RD;
          end
          default: state_d = ple_pkg::ST_IDLE;
        endcase
      end
      ple_pkg::ST_DUMP_RD: state_d = ple_pkg::ST_DUMP_EMIT;
      ple_pkg::ST_DUMP_EMIT: begin
        if (res_ready_i) begin
          state_d = (a_inc == count_q) ? ple_pkg::ST_IDLE : ple_pkg::ST_DUMP_RD;
        end
      end
      ple_pkg::ST_INS_RD: begin
        state_d = (a_q == p1_idx) ? ple_pkg::ST_INS_PUT : ple_pkg::ST_INS_WR;
      end
      ple_pkg::ST_INS_WR:  state_d = ple_pkg::ST_INS_RD;
      ple_pkg::ST_INS_PUT: state_d = ple_pkg::ST_REPLY;
      ple_pkg::ST_DEL_RD: begin
        state_d = (a_inc >= count_q) ? ple_pkg::ST_REPLY : ple_pkg::ST_DEL_WR;
      end
      ple_pkg::ST_DEL_WR: state_d = ple_pkg::ST_DEL_RD;
      ple_pkg::ST_SW_RDA: state_d = ple_pkg::ST_SW_RDB;
      ple_pkg::ST_SW_RDB: state_d = ple_pkg::ST_SW_WRA;
      ple_pkg::ST_SW_WRA: state_d = ple_pkg::ST_SW_WRB;
      ple_pkg::ST_SW_WRB: begin
        if (mode_q == ple_pkg::MODE_REVERSE && rev_more) state_d = ple_pkg::ST_SW_RDA;
        else state_d = ple_pkg::ST_REPLY;
      end
      ple_pkg::ST_FIND_RD: state_d = ple_pkg::ST_FIND_CMP;
      ple_pkg::ST_FIND_CMP: begin
        if (a_match || a_inc == count_q) state_d = ple_pkg::ST_REPLY;
        else state_d = ple_pkg::ST_FIND_RD;
      end
      ple_pkg::ST_REPLY: begin
        if (res_ready_i) state_d = ple_pkg::ST_IDLE;
      end
      default: state_d = ple_pkg::ST_IDLE;
    endcase
  end

  // Outputs and datapath updates
  always_comb begin
    mode_d      = mode_q;
    p1_d        = p1_q;
    p2_d        = p2_q;
    val_d       = val_q;
    tmp_d       = tmp_q;
    status_d    = status_q;
    pos_d       = pos_q;
    count_d     = count_q;
    a_d         = a_q;
    b_d         = b_q;
    mem_we_o    = 1'b0;
    mem_waddr_o = a_q[AW-1:0];
    mem_wdata_o = mem_rdata_i;
    mem_re_o    = 1'b0;
    mem_raddr_o = a_q[AW-1:0];
    res_valid_o = 1'b0;
    res_o       = '{status: status_q, position: pos_q, element_value: '0,
                    element_count: ple_pkg::POS_W'(count_q), last: 1'b1};
    case (state_q)
      ple_pkg::ST_IDLE: begin
        if (accept) begin
          mode_d = ple_pkg::ple_mode_e'(req_mode_i);
          p1_d   = req_pos_first_i;
          p2_d   = req_pos_second_i;
          val_d  = req_value_i;
        end
      end
      ple_pkg::ST_CHECK: begin
        status_d = ple_pkg::STAT_OK;
        pos_d    = '0;
        a_d      = '0;
        case (mode_q)
          ple_pkg::MODE_DUMP: begin
            if (count_q == '0) status_d = ple_pkg::STAT_EMPTY;
          end
          ple_pkg::MODE_INSERT: begin
            a_d = count_q;
            if (!p1_ins_ok) status_d = ple_pkg::STAT_BADPOS;
            else if (count_q == CW'(CAPACITY)) status_d = ple_pkg::STAT_FULL;
          end
          ple_pkg::MODE_DELETE: begin
            a_d = p1_idx;
            if (!p1_in_list) status_d = ple_pkg::STAT_BADPOS;
          end
          ple_pkg::MODE_SWAP: begin
            a_d = p1_idx;
            b_d = p2_idx;
            if (!(p1_in_list && p2_in_list)) status_d = ple_pkg::STAT_BADPOS;
          end
          ple_pkg::MODE_REVERSE: begin
            b_d = count_q - CW'(1);
          end
          ple_pkg::MODE_FIND: begin
            if (count_q == '0) status_d = ple_pkg::STAT_NOTFOUND;
          end
          default: ;
        endcase
      end
      ple_pkg::ST_DUMP_RD: mem_re_o = 1'b1;
      ple_pkg::ST_DUMP_EMIT: begin
        res_valid_o = 1'b1;
        res_o = '{status: ple_pkg::STAT_OK, position: ple_pkg::POS_W'(a_inc),
                  element_value: mem_rdata_i, element_count: ple_pkg::POS_W'(count_q),
                  last: (a_inc == count_q)};
        if (res_ready_i) a_d = a_inc;
      end
      ple_pkg::ST_INS_RD: begin
        mem_re_o    = (a_q != p1_idx);
        mem_raddr_o = a_dec[AW-1:0];
      end
      ple_pkg::ST_INS_WR: begin
        mem_we_o = 1'b1;
        a_d      = a_dec;
      end
      ple_pkg::ST_INS_PUT: begin
        mem_we_o    = 1'b1;
        mem_waddr_o = p1_idx[AW-1:0];
        mem_wdata_o = val_q;
        count_d     = count_q + CW'(1);
      end
      ple_pkg::ST_DEL_RD: begin
        mem_raddr_o = a_inc[AW-1:0];
        if (a_inc >= count_q) count_d = count_q - CW'(1);
        else mem_re_o = 1'b1;
      end
      ple_pkg::ST_DEL_WR: begin
        mem_we_o = 1'b1;
        a_d      = a_inc;
      end
      ple_pkg::ST_SW_RDA: mem_re_o = 1'b1;
      ple_pkg::ST_SW_RDB: begin
        mem_re_o    = 1'b1;
        mem_raddr_o = b_q[AW-1:0];
        tmp_d       = mem_rdata_i;
      end
      ple_pkg::ST_SW_WRA: mem_we_o = 1'b1;
      ple_pkg::ST_SW_WRB: begin
        mem_we_o    = 1'b1;
        mem_waddr_o = b_q[AW-1:0];
        mem_wdata_o = tmp_q;
        a_d         = a_inc;
        b_d         = b_q - CW'(1);
      end
      ple_pkg::ST_FIND_RD: mem_re_o = 1'b1;
      ple_pkg::ST_FIND_CMP: begin
        if (a_match) begin
          pos_d = ple_pkg::POS_W'(a_inc);
        end else if (a_inc == count_q) begin
          status_d = ple_pkg::STAT_NOTFOUND;
        end else begin
          a_d = a_inc;
        end
      end
      ple_pkg::ST_REPLY: res_valid_o = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ple_pkg::ST_IDLE;
      count_q <= '0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mode_q   <= mode_d;
    p1_q     <= p1_d;
    p2_q     <= p2_d;
    val_q    <= val_d;
    tmp_q    <= tmp_d;
    status_q <= status_d;
    pos_q    <= pos_d;
    a_q      <= a_d;
    b_q      <= b_d;
  end

  `PLE_ASSERT_IMPL(a_count_bound, 1'b1, count_q <= CW'(CAPACITY), "list count above capacity")
  `PLE_ASSERT_IMPL(a_count_step, !$stable(count_q),
    count_q == $past(count_q) + CW'(1) || count_q == $past(count_q) - CW'(1),
    "list count moved by more than one")
  `PLE_ASSERT_IMPL(a_no_write_on_result, res_valid_o, !mem_we_o && !mem_re_o,
    "store accessed while a result is offered")
  `PLE_ASSERT_NEXT(a_accept_check, accept, state_q == ple_pkg::ST_CHECK,
    "accepted item not decoded next cycle")

endmodule

>>> sim/tb.sv
// Self-checking testbench for positional_list_engine with a list predictor.
`timescale 1ns / 1ps
module tb;
  import ple_pkg::*;

  localparam int unsigned LIST_CAP     = 32;
  localparam int          RANDOM_REQS  = 140;
  localparam int          CALM_TAIL    = 25;
  localparam int          DRAIN_CYCLES = 100;
  localparam int          CYCLE_LIMIT  = 400000;

  localparam logic [MODE_W-1:0] MODE_SPARE_LO = 3'd6;
  localparam logic [MODE_W-1:0] MODE_SPARE_HI = 3'd7;

  typedef struct {
    logic [MODE_W-1:0] mode;
    logic [PIN_W-1:0]  pos_first;
    logic [PIN_W-1:0]  pos_second;
    logic [DATA_W-1:0] value;
  } list_request_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [47:0] s_axis_tdata = '0;
  logic [2:0]  s_axis_tuser = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [47:0] m_axis_tdata;
  logic [2:0]  m_axis_tuser;
  logic        m_axis_tlast;

  list_request_t queued_requests[$];
  ple_result_t   awaited_results[$];

  // Predicted list contents and length.
  logic signed [DATA_W-1:0] shadow_list[LIST_CAP];
  int shadow_len = 0;
  int peak_len = 0;

  // Length the generator expects, so that most positions it picks are legal.
  int plan_len = 0;

  int requests_made = 0;
  int requests_taken = 0;
  int results_seen = 0;
  int mismatches = 0;
  int status_seen[8];
  int cycle_count = 0;
  bit calm = 1'b0;

  positional_list_engine #(
    .CAPACITY(LIST_CAP)
  ) DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .m_axis_tlast (m_axis_tlast)
  );

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  // Apply one accepted request to the shadow list and queue the results it owes.
  function automatic void predict_list_request(input list_request_t req);
    ple_result_t              res;
    logic signed [DATA_W-1:0] held;
    int                       p1;
    int                       p2;
    int                       idx;
    bit                       hit;
    p1 = req.pos_first;
    p2 = req.pos_second;
    res = '{status: STAT_OK, position: '0, element_value: '0, element_count: '0, last: 1'b1};
    case (req.mode)
      MODE_DUMP: begin
        if (shadow_len == 0) begin
          res.status = STAT_EMPTY;
          awaited_results.push_back(res);
        end else begin
          for (idx = 0; idx < shadow_len; idx++) begin
            res.position      = POS_W'(idx + 1);
            res.element_value = shadow_list[idx];
            res.element_count = POS_W'(shadow_len);
            res.last          = (idx + 1 == shadow_len);
            awaited_results.push_back(res);
          end
        end
        return;
      end
      MODE_INSERT: begin
        if (p1 < 1 || p1 > shadow_len + 1) begin
          res.status = STAT_BADPOS;
        end else if (shadow_len >= LIST_CAP) begin
          res.status = STAT_FULL;
        end else begin
          for (idx = shadow_len; idx > p1 - 1; idx--) shadow_list[idx] = shadow_list[idx - 1];
          shadow_list[p1 - 1] = req.value;
          shadow_len++;
          if (shadow_len > peak_len) peak_len = shadow_len;
        end
      end
      MODE_DELETE: begin
        if (p1 < 1 || p1 > shadow_len) begin
          res.status = STAT_BADPOS;
        end else begin
          for (idx = p1 - 1; idx + 1 < shadow_len; idx++) shadow_list[idx] = shadow_list[idx + 1];
          shadow_len--;
        end
      end
      MODE_SWAP: begin
        if (p1 < 1 || p1 > shadow_len || p2 < 1 || p2 > shadow_len) begin
          res.status = STAT_BADPOS;
        end else begin
          held                = shadow_list[p1 - 1];
          shadow_list[p1 - 1] = shadow_list[p2 - 1];
          shadow_list[p2 - 1] = held;
        end
      end
      MODE_REVERSE: begin
        for (idx = 0; idx < shadow_len / 2; idx++) begin
          held                            = shadow_list[idx];
          shadow_list[idx]                = shadow_list[shadow_len - 1 - idx];
          shadow_list[shadow_len - 1 - idx] = held;
        end
      end
      MODE_FIND: begin
        hit = 1'b0;
        for (idx = 0; idx < shadow_len && !hit; idx++) begin
          if (shadow_list[idx] == $signed(req.value)) begin
            hit          = 1'b1;
            res.position = POS_W'(idx + 1);
          end
        end
        if (!hit) res.status = STAT_NOTFOUND;
      end
      default: return;  // spare modes answer nothing
    endcase
    res.element_count = POS_W'(shadow_len);
    awaited_results.push_back(res);
  endfunction

  // Queue one request and track the length the list should reach.
  function automatic void add_request(input logic [MODE_W-1:0] mode, input int p1,
                                      input int p2, input logic [DATA_W-1:0] value);
    list_request_t req;
    req.mode       = mode;
    req.pos_first  = PIN_W'(p1);
    req.pos_second = PIN_W'(p2);
    req.value      = value;
    queued_requests.push_back(req);
    requests_made++;
    if (mode == MODE_INSERT && p1 >= 1 && p1 <= plan_len + 1 && plan_len < LIST_CAP) plan_len++;
    if (mode == MODE_DELETE && p1 >= 1 && p1 <= plan_len) plan_len--;
  endfunction

  // Mostly a legal position in 1..hi, sometimes anything the field holds.
  function automatic int pick_position(input int hi);
    if (hi >= 1 && $urandom_range(0, 99) < 85) return $urandom_range(1, hi);
    return $urandom_range(0, 63);
  endfunction

  // Values come mostly from a small pool so that finds hit and duplicates appear.
  function automatic logic [DATA_W-1:0] pick_value();
    logic [DATA_W-1:0] pool[8];
    pool = '{32'h0, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000,
             32'd5, 32'd42, 32'hFFFF_FFF9, 32'd1000};
    if ($urandom_range(0, 99) < 70) return pool[$urandom_range(0, 7)];
    return $urandom;
  endfunction

  // Driver: present queued requests, with random gaps between them.
  list_request_t drive_req;
  int gap_left = 0;
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        predict_list_request(drive_req);
        requests_taken++;
      end
      calm = (queued_requests.size() < CALM_TAIL);
      if (!s_axis_tvalid || s_axis_tready) begin
        if (gap_left > 0) begin
          gap_left--;
          s_axis_tvalid <= 1'b0;
        end else if (queued_requests.size() > 0) begin
          drive_req = queued_requests.pop_front();
          s_axis_tdata  <= {4'b0, drive_req.value, drive_req.pos_second, drive_req.pos_first};
          s_axis_tuser  <= drive_req.mode;
          s_axis_tvalid <= 1'b1;
          if (!calm && $urandom_range(0, 2) == 0) gap_left = $urandom_range(1, 4);
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  task automatic compare_field(input string fname, input logic [DATA_W-1:0] want,
                               input logic [DATA_W-1:0] got);
    if (want !== got) begin
      $error("%s mismatch: expected 0x%0h, actual 0x%0h", fname, want, got);
      mismatches++;
    end
  endtask

  // Monitor: check each result item against the oldest expectation; stall at random.
  ple_result_t want_res;
  int stall_left = 0;
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        results_seen++;
        status_seen[m_axis_tuser]++;
        if (awaited_results.size() == 0) begin
          $error("result item with nothing expected: status %0d tdata 0x%0h",
                 m_axis_tuser, m_axis_tdata);
          mismatches++;
        end else begin
          want_res = awaited_results.pop_front();
          compare_field("status", DATA_W'(want_res.status), DATA_W'(m_axis_tuser));
          compare_field("position", DATA_W'(want_res.position), DATA_W'(m_axis_tdata[6:0]));
          compare_field("element_value", want_res.element_value, m_axis_tdata[38:7]);
          compare_field("element_count", DATA_W'(want_res.element_count),
                        DATA_W'(m_axis_tdata[45:39]));
          compare_field("last", DATA_W'(want_res.last), DATA_W'(m_axis_tlast));
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
        if (!calm && $urandom_range(0, 4) == 0) stall_left = $urandom_range(1, 4);
      end
    end
  end

  initial begin : watchdog
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("FAIL positional_list_engine");
    $finish;
  end

  initial begin : run_ctrl
    int k;
    int phase;
    int ins_w;
    int del_w;
    int roll;
    logic [MODE_W-1:0] mode;

    // Empty list: every defined mode, and positions just outside the legal range.
    add_request(MODE_DUMP, 0, 0, 0);
    add_request(MODE_REVERSE, 0, 0, 0);
    add_request(MODE_FIND, 0, 0, 0);
    add_request(MODE_DELETE, 1, 0, 0);
    add_request(MODE_SWAP, 1, 1, 0);
    add_request(MODE_INSERT, 0, 0, 32'd9);
    add_request(MODE_INSERT, 2, 0, 32'd9);
    add_request(MODE_INSERT, 1, 0, 32'h7FFF_FFFF);
    add_request(MODE_REVERSE, 0, 0, 0);
    // Insert at the front, the end and the middle; then dump, swap, find, reverse, delete and the spare modes.
    add_request(MODE_INSERT, 1, 0, 32'h8000_0000);
    add_request(MODE_INSERT, 3, 0, 32'h0);
    add_request(MODE_INSERT, 2, 0, 32'hFFFF_FFFF);
    add_request(MODE_DUMP, 0, 0, 0);
    add_request(MODE_SWAP, 1, 4, 0);
    add_request(MODE_SWAP, 2, 2, 0);
    add_request(MODE_SWAP, 0, 2, 0);
    add_request(MODE_SWAP, 3, 63, 0);
    add_request(MODE_FIND, 0, 0, 32'hFFFF_FFFF);
    add_request(MODE_FIND, 0, 0, 32'h8000_0000);
    add_request(MODE_FIND, 0, 0, 32'd12345);
    add_request(MODE_REVERSE, 0, 0, 0);
    add_request(MODE_DELETE, 0, 0, 0);
    add_request(MODE_DELETE, 5, 0, 0);
    add_request(MODE_DELETE, 4, 0, 0);
    add_request(MODE_DELETE, 1, 0, 0);
    add_request(MODE_SPARE_LO, 1, 1, 32'd1);
    add_request(MODE_SPARE_HI, 63, 63, 32'hFFFF_FFFF);
    add_request(MODE_DUMP, 0, 0, 0);

    // Random part: grow, mix, grow toward a full list, then shrink.
    for (k = 0; k < RANDOM_REQS; k++) begin
      phase = (k / 35) % 4;
      ins_w = (phase == 0 || phase == 2) ? 80 : (phase == 3) ? 10 : 30;
      del_w = (phase == 0 || phase == 2) ? 5 : (phase == 3) ? 65 : 25;
      roll  = $urandom_range(0, 99);
      if (roll < ins_w) begin
        mode = MODE_INSERT;
      end else if (roll < ins_w + del_w) begin
        mode = MODE_DELETE;
      end else begin
        roll = $urandom_range(0, 99);
        if (roll < 25) mode = MODE_DUMP;
        else if (roll < 55) mode = MODE_FIND;
        else if (roll < 80) mode = MODE_SWAP;
        else if (roll < 93) mode = MODE_REVERSE;
        else mode = $urandom_range(0, 1) ? MODE_SPARE_HI : MODE_SPARE_LO;
      end
      case (mode)
        MODE_INSERT: add_request(mode, pick_position(plan_len + 1), $urandom_range(0, 63),
                                 pick_value());
        MODE_DELETE: add_request(mode, pick_position(plan_len), $urandom_range(0, 63),
                                 $urandom);
        MODE_SWAP:   add_request(mode, pick_position(plan_len), pick_position(plan_len),
                                 $urandom);
        MODE_FIND:   add_request(mode, $urandom_range(0, 63), $urandom_range(0, 63),
                                 pick_value());
        default:     add_request(mode, $urandom_range(0, 63), $urandom_range(0, 63),
                                 $urandom);
      endcase
    end

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (requests_taken < requests_made || awaited_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Covered %0d requests and %0d result items; longest list %0d of %0d.",
             requests_taken, results_seen, peak_len, LIST_CAP);
    $display("Status counts ok/badpos/full/notfound/empty: %0d/%0d/%0d/%0d/%0d",
             status_seen[STAT_OK], status_seen[STAT_BADPOS], status_seen[STAT_FULL],
             status_seen[STAT_NOTFOUND], status_seen[STAT_EMPTY]);
    if (mismatches == 0) begin
      $display("PASS positional_list_engine");
    end else begin
      $display("FAIL positional_list_engine");
    end
    $finish;
  end

endmodule
